FILE: hw/rtl/dtsr_pkg.sv
package dtsr_pkg;

  localparam int unsigned DEC_W = 4;
  localparam int unsigned DIGIT_STEPS = 4;
  localparam int unsigned DIGIT_STAGES = DIGIT_STEPS + 2;

  function automatic longint unsigned pow10(input int unsigned k);
    longint unsigned p;
    p = 64'd1;
    for (int unsigned i = 0; i < k; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

FILE: hw/rtl/decimal_truncated_square_root_unit.sv
// Pipelined exact square root truncated to a chosen number of decimal places.
// Each item carries a radicand and a decimal count (saturated to MAX_DECIMALS) and
// yields floor(sqrt(radicand) * 10^decimals) together with the count applied.
// One item enters per cycle while the output is not stalled. The pipeline holds an input
// register, then one stage per binary root bit, then for each decimal place a scale stage,
// four trial stages for the digit bits and a commit stage.
// A stall at the output freezes the whole pipeline, so no item is lost or repeated.
module decimal_truncated_square_root_unit import dtsr_pkg::*; #(
  parameter int unsigned MAX_DECIMALS  = 9,
  parameter int unsigned RADICAND_BITS = 31,
  localparam int unsigned HB = (RADICAND_BITS + 1) / 2,
  localparam int unsigned RW = HB + $clog2(pow10(MAX_DECIMALS)),
  localparam int unsigned IW = ((RADICAND_BITS + DEC_W + 7) / 8) * 8,
  localparam int unsigned OW = ((RW + DEC_W + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // radicand, decimals
  input  logic [IW-1:0] s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // root_scaled, decimals_used
  output logic [OW-1:0] m_axis_tdata
);

  localparam int unsigned MW = RW + 2;
  localparam int unsigned TW = RW + 10;
  localparam int unsigned NS = HB + DIGIT_STAGES * MAX_DECIMALS;

  typedef struct packed {
    logic [2*HB-1:0] n;
    logic [DEC_W-1:0] k;
    logic [RW-1:0] r;
    logic [MW-1:0] rem;
    logic [TW-1:0] tgt;
    logic [TW-1:0] used;
    logic [DEC_W-1:0] d;
  } stage_t;

  stage_t          p_q [NS+1];
  stage_t          p_d [NS+1];
  logic   [NS:0]   v_q;
  logic            en;

  logic [DEC_W-1:0] dec_in;
  logic [DEC_W-1:0] dec_sat;

  assign en = !v_q[NS] || m_axis_tready;
  assign s_axis_tready = en;

  assign dec_in  = s_axis_tdata[RADICAND_BITS +: DEC_W];
  assign dec_sat = (32'(dec_in) > MAX_DECIMALS) ? DEC_W'(MAX_DECIMALS) : dec_in;

  always_comb begin
    p_d[0]      = '0;
    p_d[0].n    = (2*HB)'(s_axis_tdata[RADICAND_BITS-1:0]);
    p_d[0].k    = dec_sat;
  end

  // binary root bits
  for (genvar j = 0; j < HB; j++) begin : g_int
    localparam int unsigned BP = HB - 1 - j;
    logic [MW-1:0] shifted;
    logic [MW-1:0] trial;
    always_comb begin
      p_d[j+1] = p_q[j];
      shifted  = MW'({p_q[j].rem, p_q[j].n[2*BP+1 -: 2]});
      trial    = MW'({p_q[j].r, 2'b01});
      if (shifted >= trial) begin
        p_d[j+1].rem = shifted - trial;
        p_d[j+1].r   = RW'({p_q[j].r, 1'b1});
      end else begin
        p_d[j+1].rem = shifted;
        p_d[j+1].r   = RW'({p_q[j].r, 1'b0});
      end
    end
  end

  // decimal digits
  for (genvar i = 0; i < MAX_DECIMALS; i++) begin : g_dec
    localparam int unsigned B = HB + DIGIT_STAGES * i;
    always_comb begin
      p_d[B+1]      = p_q[B];
      p_d[B+1].tgt  = (TW'(p_q[B].rem) << 6) + (TW'(p_q[B].rem) << 5) + (TW'(p_q[B].rem) << 2);
      p_d[B+1].used = '0;
      p_d[B+1].d    = '0;
    end
    for (genvar t = 0; t < DIGIT_STEPS; t++) begin : g_bit
      localparam int unsigned S  = B + 1 + t;
      localparam int unsigned SH = DIGIT_STEPS - 1 - t;
      logic [TW-1:0] cand;
      always_comb begin
        p_d[S+1] = p_q[S];
        cand = p_q[S].used
             + (((TW'(p_q[S].r) << 4) + (TW'(p_q[S].r) << 2)) << SH)
             + (TW'(p_q[S].d) << (SH + 1))
             + (TW'(1) << (2 * SH));
        if (cand <= p_q[S].tgt) begin
          p_d[S+1].used = cand;
          p_d[S+1].d    = p_q[S].d | DEC_W'(1 << SH);
        end
      end
    end
    localparam int unsigned C = B + 1 + DIGIT_STEPS;
    always_comb begin
      p_d[C+1] = p_q[C];
      if (32'(p_q[C].k) > i) begin
        p_d[C+1].rem = MW'(p_q[C].tgt - p_q[C].used);
        p_d[C+1].r   = (p_q[C].r << 3) + (p_q[C].r << 1) + RW'(p_q[C].d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:0], s_axis_tvalid};
    end
  end

  for (genvar s = 0; s <= NS; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[s] <= (s == 0) ? p_d[0] : p_d[s];
      end
    end
  end

  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = OW'({p_q[NS].k, p_q[NS].r});

  a_dec_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(p_q[NS].k) <= MAX_DECIMALS)
    else $error("decimal count above limit at output");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_int_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && p_q[NS].k == '0) |-> (p_q[NS].r >> HB) == '0)
    else $error("integer root wider than radicand allows");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> MW'(p_q[NS].rem) <= (MW'(p_q[NS].r) << 1))
    else $error("remainder exceeds twice the root");

endmodule
